// ----- design/cts_pkg.sv -----
// ============================================================================
// cts_pkg - shared types and constants for the cooperative task scheduler
// Command, outcome, status and slot-state codes, and the transaction structs.
// ============================================================================
package cts_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int NUM_LINES_DEF = 64;
    localparam logic [31:0] BUDGET_RESET = 32'd1024;
    localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        CMD_CREATE   = 3'd0,
        CMD_DISPATCH = 3'd1,
        CMD_OUTCOME  = 3'd2,
        CMD_TICK     = 3'd3,
        CMD_QUERY    = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        OC_DONE  = 3'd0,
        OC_YIELD = 3'd1,
        OC_RD    = 3'd2,
        OC_WR    = 3'd3,
        OC_SLEEP = 3'd4
    } oc_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_DISPATCHED = 3'd1,
        ST_BLOCKED    = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_IGNORED    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        SS_FREE    = 3'd0,
        SS_QUEUED  = 3'd1,
        SS_RUNNING = 3'd2,
        SS_WAITING = 3'd3,
        SS_DONE    = 3'd4
    } sstate_t;

    typedef enum logic [1:0] {
        SORT_NONE  = 2'd0,
        SORT_READ  = 2'd1,
        SORT_WRITE = 2'd2,
        SORT_SLEEP = 2'd3
    } sort_t;

    typedef enum logic [3:0] {
        FSM_IDLE,
        FSM_RD,      // read slot entry
        FSM_EXEC,    // act on slot entry
        FSM_CRD,     // wake scan: read waiter
        FSM_CEXEC,   // wake scan: test waiter
        FSM_POPRD,   // read ring head
        FSM_POPMEM,  // read entry of ring head
        FSM_POP,     // dispatch ring head
        FSM_BRD,     // blocked scan: read waiter
        FSM_BEXEC,   // blocked scan: accumulate
        FSM_DONE
    } fsm_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  task_slot;
        logic [2:0]  outcome;
        logic [5:0]  event_line;
        logic [31:0] sleep_ms;
        logic [47:0] now_ms;
        logic [63:0] read_ready;
        logic [63:0] write_ready;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  chosen_slot;
        logic        preempt;
        logic        has_timer;
        logic [47:0] min_timeout_ms;
        logic [4:0]  event_waiters;
        logic [2:0]  slot_state;
    } rsp_t;

endpackage

// ----- design/cooperative_task_scheduler.sv -----
// ============================================================================
// cooperative_task_scheduler - FIFO run queue with timed and event waits
// Per-slot entries live in one synchronous memory; a sequencer reads,
// modifies and writes back one entry at a time.
// ============================================================================
// One command is taken while busy is low and its result appears, marked by
// done for one cycle; done cannot be held off. Create, outcome, tick and
// query read the slot entry and act on it before done. Dispatch with a
// queued task reads the ring head and then its slot entry in turn before
// done. When the run queue is empty it walks the wait list once to wake
// ready waiters, reading each waiter through the slot memory port, and,
// if nothing woke, walks it again for the blocked report. Configuration
// writes are taken whenever offered.
module cooperative_task_scheduler #(
    parameter int NUM_SLOTS = cts_pkg::NUM_SLOTS_DEF,
    parameter int NUM_LINES = cts_pkg::NUM_LINES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cts_pkg::req_t req,
    output logic          done,
    output cts_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int PW = SW + 1;             // slot index or null marker
    localparam logic [PW-1:0] NIL = PW'(NUM_SLOTS);

    // one entry per slot
    typedef struct packed {
        logic [PW-1:0] link;
        logic [1:0]    sort;
        logic [5:0]    line;
        logic [47:0]   deadline;
        logic [31:0]   ticks;
    } ent_t;

    ent_t          mem [NUM_SLOTS];
    logic [SW-1:0] ring [NUM_SLOTS];
    logic [2:0]    sstat_reg [NUM_SLOTS];   // reset to free
    logic [NUM_SLOTS-1:0] wv_reg;           // entry written since reset

    logic [31:0]   budget_reg;
    cts_pkg::fsm_t state_reg, state_next;
    cts_pkg::req_t req_reg;
    cts_pkg::rsp_t rsp_reg, rsp_next;
    logic [SW-1:0] head_reg, head_next;
    logic [PW-1:0] count_reg, count_next;
    logic [PW-1:0] first_reg, first_next;
    logic [PW-1:0] cur_reg, cur_next, prev_reg, prev_next;
    logic [PW-1:0] guard_reg, guard_next;
    logic [47:0]   best_reg, best_next;
    logic          timer_reg, timer_next;
    logic [4:0]    evc_reg, evc_next;

    // memory ports
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    ent_t          rd_data;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    ent_t          wr_data;
    logic          pl_en;                    // patch link of another entry
    logic [SW-1:0] pl_addr;
    logic          rg_en;
    logic [SW-1:0] rg_addr, rg_wdata, rg_rdata;
    logic          st_en;
    logic [SW-1:0] st_addr;
    logic [2:0]    st_data;

    logic [SW-1:0] slot;
    logic          slot_ok;

    assign slot    = SW'(req_reg.task_slot);
    assign slot_ok = {28'd0, req_reg.task_slot} < NUM_SLOTS;
    assign busy    = (state_reg != cts_pkg::FSM_IDLE);
    assign cfg_ready = 1'b1;
    assign done    = (state_reg == cts_pkg::FSM_DONE);
    assign rsp     = rsp_reg;

    function automatic logic line_rdy(input logic [63:0] m, input logic [5:0] l);
        if ({26'd0, l} >= NUM_LINES)
            return 1'b1;
        return m[l];
    endfunction

    // slot memory: one read and one write port, plus link patch via write port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
        else if (pl_en)
            mem[pl_addr].link <= wr_data.link;
        if (rg_en)
            ring[rg_addr] <= rg_wdata;
        rg_rdata <= ring[head_reg];
    end

    // hold slot states
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                sstat_reg[i] <= cts_pkg::SS_FREE;
        end
        else if (st_en)
            sstat_reg[st_addr] <= st_data;
    end

    // mark entries written since reset; unwritten ones count as zero ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wv_reg <= '0;
        else if (wr_en)
            wv_reg[wr_addr] <= 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cts_pkg::FSM_IDLE;
            budget_reg <= cts_pkg::BUDGET_RESET;
            head_reg   <= '0;
            count_reg  <= '0;
            first_reg  <= NIL;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            first_reg <= first_next;
            if (cfg_valid && cfg_ready)
                budget_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            req_reg <= req;
        rsp_reg   <= rsp_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        guard_reg <= guard_next;
        best_reg  <= best_next;
        timer_reg <= timer_next;
        evc_reg   <= evc_next;
    end

    // next state
    always_comb
    begin
        logic [PW-1:0] nxt;
        state_next = state_reg;
        nxt = rd_data.link;
        unique case (state_reg)
            cts_pkg::FSM_IDLE:
                if (start)
                    state_next = cts_pkg::FSM_RD;
            cts_pkg::FSM_RD:
                state_next = cts_pkg::FSM_EXEC;
            cts_pkg::FSM_EXEC:
                if (req_reg.command == cts_pkg::CMD_DISPATCH)
                begin
                    if (count_reg != 0)
                        state_next = cts_pkg::FSM_POPRD;
                    else if (first_reg != NIL)
                        state_next = cts_pkg::FSM_CRD;
                    else
                        state_next = cts_pkg::FSM_DONE;
                end
                else
                    state_next = cts_pkg::FSM_DONE;
            cts_pkg::FSM_CRD:
                state_next = cts_pkg::FSM_CEXEC;
            cts_pkg::FSM_CEXEC:
                if (nxt < NIL && (guard_reg + 1'b1) < NIL)
                    state_next = cts_pkg::FSM_CRD;
                else if (count_next != 0)
                    state_next = cts_pkg::FSM_POPRD;
                else if (first_next != NIL)
                    state_next = cts_pkg::FSM_BRD;
                else
                    state_next = cts_pkg::FSM_DONE;
            cts_pkg::FSM_POPRD:
                state_next = cts_pkg::FSM_POPMEM;
            cts_pkg::FSM_POPMEM:
                state_next = cts_pkg::FSM_POP;
            cts_pkg::FSM_POP:
                state_next = cts_pkg::FSM_DONE;
            cts_pkg::FSM_BRD:
                state_next = cts_pkg::FSM_BEXEC;
            cts_pkg::FSM_BEXEC:
                if (nxt < NIL && (guard_reg + 1'b1) < NIL)
                    state_next = cts_pkg::FSM_BRD;
                else
                    state_next = cts_pkg::FSM_DONE;
            cts_pkg::FSM_DONE:
                state_next = cts_pkg::FSM_IDLE;
            default:
                state_next = cts_pkg::FSM_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic [48:0]   dl;
        logic [31:0]   tk;
        logic [31:0]   c;
        logic          rdy;
        logic [47:0]   left;
        logic [2:0]    ss;
        logic [PW-1:0] tail;
        logic [PW-1:0] hn;
        rd_en = 1'b0; rd_addr = slot;
        wr_en = 1'b0; wr_addr = slot; wr_data = rd_data;
        pl_en = 1'b0; pl_addr = prev_reg[SW-1:0];
        // wrap the ring tail by compare and subtract
        tail = {1'b0, head_reg} + count_reg;
        rg_en = 1'b0; rg_addr = (tail >= NIL) ? SW'(tail - NIL) : SW'(tail);
        rg_wdata = slot;
        st_en = 1'b0; st_addr = slot; st_data = cts_pkg::SS_QUEUED;
        head_next = head_reg; count_next = count_reg; first_next = first_reg;
        cur_next = cur_reg; prev_next = prev_reg; guard_next = guard_reg;
        best_next = best_reg; timer_next = timer_reg; evc_next = evc_reg;
        rsp_next = rsp_reg;
        dl = 49'({1'b0, req_reg.now_ms} + {17'd0, req_reg.sleep_ms});
        tk = wv_reg[slot] ? rd_data.ticks : 32'd0;
        c = tk + 32'd1;
        hn = {1'b0, head_reg} + 1'b1;
        rdy = 1'b0; left = '0;
        ss = sstat_reg[slot];
        unique case (state_reg)
            cts_pkg::FSM_RD:
            begin
                rd_en = 1'b1;
                rsp_next = '0;
                rsp_next.status = cts_pkg::ST_IGNORED;
            end
            cts_pkg::FSM_EXEC:
            begin
                case (req_reg.command)
                    cts_pkg::CMD_CREATE:
                        if (slot_ok && (ss == cts_pkg::SS_FREE || ss == cts_pkg::SS_DONE))
                        begin
                            wr_en = 1'b1; wr_data.ticks = '0;
                            rsp_next.status = cts_pkg::ST_OK;
                            if (count_reg < NIL)
                            begin
                                rg_en = 1'b1; st_en = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                    cts_pkg::CMD_DISPATCH:
                    begin
                        cur_next = first_reg; prev_next = NIL; guard_next = '0;
                        best_next = cts_pkg::MASK48; timer_next = 1'b0; evc_next = '0;
                    end
                    cts_pkg::CMD_OUTCOME:
                        if (slot_ok && req_reg.outcome <= cts_pkg::OC_SLEEP
                            && ss == cts_pkg::SS_RUNNING)
                        begin
                            rsp_next.status = cts_pkg::ST_OK;
                            if (req_reg.outcome == cts_pkg::OC_DONE)
                            begin
                                st_en = 1'b1; st_data = cts_pkg::SS_DONE;
                            end
                            else if (req_reg.outcome == cts_pkg::OC_YIELD
                                || (req_reg.outcome == cts_pkg::OC_SLEEP
                                    && req_reg.sleep_ms == 0)
                                || (req_reg.outcome == cts_pkg::OC_RD
                                    && line_rdy(req_reg.read_ready, req_reg.event_line))
                                || (req_reg.outcome == cts_pkg::OC_WR
                                    && line_rdy(req_reg.write_ready, req_reg.event_line)))
                            begin
                                if (count_reg < NIL)
                                begin
                                    rg_en = 1'b1; st_en = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (req_reg.outcome == cts_pkg::OC_SLEEP)
                                begin
                                    wr_data.deadline = dl[48] ? cts_pkg::MASK48 : dl[47:0];
                                    wr_data.sort = cts_pkg::SORT_SLEEP;
                                    wr_data.line = '0;
                                end
                                else
                                begin
                                    wr_data.deadline = '0;
                                    wr_data.sort = (req_reg.outcome == cts_pkg::OC_RD) ?
                                        cts_pkg::SORT_READ : cts_pkg::SORT_WRITE;
                                    wr_data.line = req_reg.event_line;
                                end
                                wr_data.link = first_reg;
                                first_next = {1'b0, slot};
                                st_en = 1'b1; st_data = cts_pkg::SS_WAITING;
                            end
                        end
                    cts_pkg::CMD_TICK:
                        if (slot_ok)
                        begin
                            rsp_next.status = cts_pkg::ST_OK;
                            if (budget_reg != 0)
                            begin
                                wr_en = 1'b1;
                                if (c >= budget_reg || c == 0)
                                begin
                                    wr_data.ticks = '0; rsp_next.preempt = 1'b1;
                                end
                                else
                                    wr_data.ticks = c;
                            end
                        end
                    cts_pkg::CMD_QUERY:
                        if (slot_ok)
                        begin
                            rsp_next.status = cts_pkg::ST_OK;
                            rsp_next.slot_state = ss;
                        end
                    default: ;
                endcase
            end
            cts_pkg::FSM_CRD, cts_pkg::FSM_BRD:
            begin
                rd_en = 1'b1; rd_addr = cur_reg[SW-1:0];
            end
            cts_pkg::FSM_CEXEC:
            begin
                guard_next = guard_reg + 1'b1;
                case (rd_data.sort)
                    cts_pkg::SORT_READ:
                        rdy = line_rdy(req_reg.read_ready, rd_data.line);
                    cts_pkg::SORT_WRITE:
                        rdy = line_rdy(req_reg.write_ready, rd_data.line);
                    cts_pkg::SORT_SLEEP:
                        rdy = req_reg.now_ms >= rd_data.deadline;
                    default:
                        rdy = 1'b1;
                endcase
                if (rdy)
                begin
                    // unlink and queue
                    if (prev_reg == NIL)
                        first_next = rd_data.link;
                    else
                    begin
                        pl_en = 1'b1; wr_data.link = rd_data.link;
                    end
                    if (count_reg < NIL)
                    begin
                        rg_en = 1'b1; rg_wdata = cur_reg[SW-1:0];
                        st_en = 1'b1; st_addr = cur_reg[SW-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                    prev_next = cur_reg;
                cur_next = rd_data.link;
                if (state_next == cts_pkg::FSM_BRD)
                begin
                    cur_next = first_next; guard_next = '0;
                end
            end
            cts_pkg::FSM_POPMEM:
            begin
                rd_en = 1'b1; rd_addr = rg_rdata;
            end
            cts_pkg::FSM_POP:
            begin
                wr_en = 1'b1; wr_addr = rg_rdata;
                wr_data.ticks = '0;
                st_en = 1'b1; st_addr = rg_rdata; st_data = cts_pkg::SS_RUNNING;
                head_next = (hn >= NIL) ? '0 : SW'(hn);
                count_next = count_reg - 1'b1;
                rsp_next.status = cts_pkg::ST_DISPATCHED;
                rsp_next.chosen_slot = 4'(rg_rdata);
            end
            cts_pkg::FSM_BEXEC:
            begin
                guard_next = guard_reg + 1'b1;
                cur_next = rd_data.link;
                if (rd_data.sort == cts_pkg::SORT_SLEEP)
                begin
                    left = (rd_data.deadline > req_reg.now_ms) ?
                        rd_data.deadline - req_reg.now_ms : '0;
                    if (!timer_reg || left < best_reg)
                        best_next = left;
                    timer_next = 1'b1;
                end
                else if (evc_reg < 5'd31)
                    evc_next = evc_reg + 1'b1;
                if (state_next == cts_pkg::FSM_DONE)
                begin
                    rsp_next.status = cts_pkg::ST_BLOCKED;
                    rsp_next.has_timer = timer_next;
                    rsp_next.min_timeout_ms = timer_next ? best_next : '0;
                    rsp_next.event_waiters = evc_next;
                end
            end
            default: ;
        endcase
        if (state_reg == cts_pkg::FSM_EXEC && req_reg.command == cts_pkg::CMD_DISPATCH
            && count_reg == 0 && first_reg == NIL)
            rsp_next.status = cts_pkg::ST_EMPTY;
        if (state_reg == cts_pkg::FSM_CEXEC && state_next == cts_pkg::FSM_DONE)
            rsp_next.status = cts_pkg::ST_EMPTY;
    end

    // checks
    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= NIL;
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("run count overflow");

    property p_done_pulse;
        @(posedge clk) disable iff (!rst_n) done |=> !done;
    endproperty
    a_done_pulse: assert property (p_done_pulse) else $error("done held");

    property p_start_busy;
        @(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy;
    endproperty
    a_start_busy: assert property (p_start_busy) else $error("command not taken");

    property p_chosen;
        @(posedge clk) disable iff (!rst_n)
            (done && rsp.status != cts_pkg::ST_DISPATCHED) |-> rsp.chosen_slot == 0;
    endproperty
    a_chosen: assert property (p_chosen) else $error("stray chosen slot");

endmodule
